// File: src/crcts_pkg.sv
package crcts_pkg;

	// Number of 32-bit words in the running sum and in the step value
	localparam int WORD_COUNT = 23;
	localparam int ADDR_W     = $clog2(WORD_COUNT);
	localparam int COUNT_W    = 48;

	typedef logic [ADDR_W-1:0] addr_t;

	localparam logic [31:0]        CRC_POLY  = 32'hedb88320;
	localparam logic [31:0]        TAIL_MASK = 32'hfffffffc;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Sum words that feed the candidate bytes, big-endian from the top word down.
	// The head word gives only its low half to the CRC; the tail word is taken
	// from the low byte of one word and the upper three bytes of the next.
	localparam addr_t HEAD_WORD     = addr_t'(22);
	localparam addr_t LAST_CRC_WORD = addr_t'(16);
	localparam addr_t TAIL_LO_WORD  = addr_t'(15);
	localparam addr_t TAIL_HI_WORD  = addr_t'(14);

	typedef enum logic [1:0] {
		MODE_LOAD_SUM  = 2'd0,
		MODE_LOAD_STEP = 2'd1,
		MODE_TEST      = 2'd2,
		MODE_READ      = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_CRC_ISSUE,
		ST_CRC_LOAD,
		ST_CRC_RUN,
		ST_ADD,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic       init;
		logic       load;
		logic [2:0] nbytes;
	} crc_ctrl_t;

	// One byte of a reflected CRC-32
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: src/crcts_ram.sv
module crcts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 23
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/crcts_crc.sv
module crcts_crc (
	input  logic                clk,
	input  logic                arst_n,
	input  crcts_pkg::crc_ctrl_t ctrl,
	input  logic [31:0]         seed,
	input  logic [31:0]         word,
	output logic                busy,
	output logic [31:0]         crc
);

	logic [31:0] crc_q;
	logic [31:0] shreg_q;
	logic [2:0]  left_q;

	// Consume one byte per cycle from the top of the shift register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= '0;
			left_q <= '0;
		end else if (ctrl.init) begin
			crc_q  <= seed;
			left_q <= '0;
		end else if (ctrl.load) begin
			left_q <= ctrl.nbytes;
		end else if (left_q != 3'd0) begin
			crc_q  <= crcts_pkg::crc_byte(crc_q, shreg_q[31:24]);
			left_q <= left_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			shreg_q <= word;
		end else if (left_q != 3'd0) begin
			shreg_q <= {shreg_q[23:0], 8'd0};
		end
	end

	assign busy = (left_q != 3'd0);
	assign crc  = crc_q;

endmodule

// File: src/crcts_add.sv
module crcts_add (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        first,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] sum
);

	logic        carry_q;
	logic        cin;
	logic [32:0] total;

	// Drop the carry into the lowest word
	assign cin   = first ? 1'b0 : carry_q;
	assign total = {1'b0, a} + {1'b0, b} + {32'd0, cin};
	assign sum   = total[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= 1'b0;
		end else if (en) begin
			carry_q <= total[32];
		end
	end

endmodule

// File: src/crc_tail_signature_search.sv
// Timing: a load gives no result; a read answers from a registered RAM read; a test runs
// 7 sum words through the byte-serial CRC, then 2 tail words, each behind a registered
// RAM read, and on a miss adds the step into the sum one word at a time over all words.
// Flow: one word at a time; a new word is taken in the cycle m_tvalid rises, not while a
// test or read is in progress; a result not yet taken holds the next one back.
// Reset: arst_n async, active low; clears FSM, counter, prefix CRC (all ones); RAMs keep data.
module crc_tail_signature_search (
	input  logic         clk,
	input  logic         arst_n,
	// configuration: prefix CRC
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	// input words
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,  // [4:0] word_index, [36:5] word_value, [39:37] zero
	input  logic [1:0]   s_tuser,  // [1:0] mode
	// result words
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [79:0]  m_tdata,  // [31:0] read_value, [79:32] tested_total
	output logic [0:0]   m_tuser   // [0] matched
);

	typedef crcts_pkg::addr_t addr_t;

	// --------------------------------------------------------------------
	// Input word decode
	// --------------------------------------------------------------------
	crcts_pkg::mode_t mode;
	logic [4:0]       word_index;
	logic [31:0]      word_value;
	logic             idx_ok;
	addr_t            idx_addr;
	logic             s_fire;

	assign mode       = crcts_pkg::mode_t'(s_tuser[1:0]);
	assign word_index = s_tdata[4:0];
	assign word_value = s_tdata[36:5];
	// Out-of-range indices: loads are dropped, reads return zero
	assign idx_ok     = ({1'b0, word_index} < 6'(crcts_pkg::WORD_COUNT));
	assign idx_addr   = word_index[crcts_pkg::ADDR_W-1:0];
	assign s_fire     = s_tvalid && s_tready;

	// --------------------------------------------------------------------
	// State
	// --------------------------------------------------------------------
	crcts_pkg::state_t state_q, state_d;

	logic [31:0]                    prefix_crc_q;
	logic [crcts_pkg::COUNT_W-1:0]  cnt_q;
	addr_t                          wp_q;      // word pointer for the CRC pass
	addr_t                          ai_q;      // read pointer for the add pass
	logic                           issue_done_q;
	logic                           rd_vld_s1;
	addr_t                          addr_s1;
	logic                           rd_ok_q;
	logic [7:0]                     tail_lo_q;
	logic                           res_match_q;
	logic [31:0]                    res_val_q;

	logic                           m_tvalid_q;
	logic [31:0]                    out_val_q;
	logic [crcts_pkg::COUNT_W-1:0]  out_total_q;
	logic                           out_match_q;

	logic push_ok;
	assign push_ok = !m_tvalid_q || m_tready;

	// --------------------------------------------------------------------
	// RAMs, CRC engine and adder
	// --------------------------------------------------------------------
	logic        sum_we, step_we;
	addr_t       sum_waddr, sum_raddr, step_waddr;
	logic [31:0] sum_wdata, step_wdata;
	logic [31:0] sum_rdata, step_rdata;

	crcts_ram #(
		.WIDTH (32),
		.DEPTH (crcts_pkg::WORD_COUNT)
	) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	crcts_ram #(
		.WIDTH (32),
		.DEPTH (crcts_pkg::WORD_COUNT)
	) u_step_ram (
		.clk   (clk),
		.we    (step_we),
		.waddr (step_waddr),
		.wdata (step_wdata),
		.raddr (ai_q),
		.rdata (step_rdata)
	);

	crcts_pkg::crc_ctrl_t crc_ctrl;
	logic [31:0]          crc_word;
	logic                 crc_busy;
	logic [31:0]          crc_val;

	crcts_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.seed   (prefix_crc_q),
		.word   (crc_word),
		.busy   (crc_busy),
		.crc    (crc_val)
	);

	logic [31:0] add_sum;

	crcts_add u_add (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (rd_vld_s1),
		.first  (addr_s1 == addr_t'(0)),
		.a      (sum_rdata),
		.b      (step_rdata),
		.sum    (add_sum)
	);

	// Tail check on the word that closes the candidate: low byte from the word
	// above, upper three bytes of this one, reassembled little-endian
	logic [31:0] tail_word;
	logic        hit;

	assign tail_word = {sum_rdata[15:8], sum_rdata[23:16], sum_rdata[31:24], tail_lo_q};
	assign hit       = (tail_word & crcts_pkg::TAIL_MASK) ==
	                   (~crc_val & crcts_pkg::TAIL_MASK);

	logic add_last;
	assign add_last = issue_done_q && rd_vld_s1;

	// --------------------------------------------------------------------
	// Next state
	// --------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			crcts_pkg::ST_IDLE: begin
				if (s_fire && mode == crcts_pkg::MODE_READ) begin
					state_d = crcts_pkg::ST_RD_WAIT;
				end else if (s_fire && mode == crcts_pkg::MODE_TEST) begin
					state_d = crcts_pkg::ST_CRC_ISSUE;
				end
			end
			crcts_pkg::ST_RD_WAIT:   state_d = crcts_pkg::ST_PUSH;
			crcts_pkg::ST_CRC_ISSUE: state_d = crcts_pkg::ST_CRC_LOAD;
			crcts_pkg::ST_CRC_LOAD: begin
				if (wp_q == crcts_pkg::TAIL_HI_WORD) begin
					state_d = hit ? crcts_pkg::ST_PUSH : crcts_pkg::ST_ADD;
				end else if (wp_q == crcts_pkg::TAIL_LO_WORD) begin
					state_d = crcts_pkg::ST_CRC_ISSUE;
				end else begin
					state_d = crcts_pkg::ST_CRC_RUN;
				end
			end
			crcts_pkg::ST_CRC_RUN: begin
				if (!crc_busy) begin
					state_d = crcts_pkg::ST_CRC_ISSUE;
				end
			end
			crcts_pkg::ST_ADD: begin
				if (add_last) begin
					state_d = crcts_pkg::ST_PUSH;
				end
			end
			crcts_pkg::ST_PUSH: begin
				if (push_ok) begin
					state_d = crcts_pkg::ST_IDLE;
				end
			end
			default: state_d = crcts_pkg::ST_IDLE;
		endcase
	end

	// --------------------------------------------------------------------
	// Outputs of the sequencer: RAM ports, CRC control, handshake
	// --------------------------------------------------------------------
	always_comb begin
		s_tready        = 1'b0;
		sum_we          = 1'b0;
		sum_waddr       = idx_addr;
		sum_wdata       = word_value;
		sum_raddr       = wp_q;
		step_we         = 1'b0;
		step_waddr      = idx_addr;
		step_wdata      = word_value;
		crc_ctrl.init   = 1'b0;
		crc_ctrl.load   = 1'b0;
		crc_ctrl.nbytes = 3'd4;
		crc_word        = sum_rdata;
		unique case (state_q)
			crcts_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				sum_raddr = idx_addr;
				if (s_fire && idx_ok && mode == crcts_pkg::MODE_LOAD_SUM) begin
					sum_we = 1'b1;
				end
				if (s_fire && idx_ok && mode == crcts_pkg::MODE_LOAD_STEP) begin
					step_we = 1'b1;
				end
				if (s_fire && mode == crcts_pkg::MODE_TEST) begin
					crc_ctrl.init = 1'b1;
				end
			end
			crcts_pkg::ST_CRC_LOAD: begin
				// Head word gives only its low half; words down to the last CRC word
				// give all four bytes
				if (wp_q >= crcts_pkg::LAST_CRC_WORD) begin
					crc_ctrl.load = 1'b1;
				end
				if (wp_q == crcts_pkg::HEAD_WORD) begin
					crc_ctrl.nbytes = 3'd2;
					crc_word        = {sum_rdata[15:0], 16'd0};
				end
			end
			crcts_pkg::ST_ADD: begin
				sum_raddr = ai_q;
				sum_waddr = addr_s1;
				sum_wdata = add_sum;
				sum_we    = rd_vld_s1;
			end
			default: begin
			end
		endcase
	end

	// --------------------------------------------------------------------
	// Registers
	// --------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= crcts_pkg::ST_IDLE;
			prefix_crc_q <= 32'hffffffff;
			cnt_q        <= '0;
			wp_q         <= '0;
			ai_q         <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				prefix_crc_q <= cfg_wdata;
			end
			// Start a test: bump the saturating counter, point at the head word
			if (state_q == crcts_pkg::ST_IDLE && s_fire && mode == crcts_pkg::MODE_TEST) begin
				if (cnt_q != crcts_pkg::COUNT_MAX) begin
					cnt_q <= cnt_q + 1'b1;
				end
				wp_q <= crcts_pkg::HEAD_WORD;
			end
			// Step down one word after each load state of the CRC pass but the last
			if (state_q == crcts_pkg::ST_CRC_LOAD && wp_q != crcts_pkg::TAIL_HI_WORD) begin
				wp_q <= wp_q - addr_t'(1);
			end
			// Arm the add pass on a miss
			if (state_q == crcts_pkg::ST_CRC_LOAD && state_d == crcts_pkg::ST_ADD) begin
				ai_q         <= '0;
				issue_done_q <= 1'b0;
				rd_vld_s1    <= 1'b0;
			end
			if (state_q == crcts_pkg::ST_ADD) begin
				rd_vld_s1 <= !issue_done_q;
				if (!issue_done_q) begin
					if (ai_q == addr_t'(crcts_pkg::WORD_COUNT - 1)) begin
						issue_done_q <= 1'b1;
					end else begin
						ai_q <= ai_q + addr_t'(1);
					end
				end
			end
			// Output register: hold until taken, refill from the result stage
			if (state_q == crcts_pkg::ST_PUSH && push_ok) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == crcts_pkg::ST_IDLE) begin
			rd_ok_q <= idx_ok;
		end
		if (state_q == crcts_pkg::ST_ADD) begin
			addr_s1 <= ai_q;
		end
		if (state_q == crcts_pkg::ST_RD_WAIT) begin
			res_match_q <= 1'b0;
			res_val_q   <= rd_ok_q ? sum_rdata : 32'd0;
		end
		if (state_q == crcts_pkg::ST_CRC_LOAD && wp_q == crcts_pkg::TAIL_LO_WORD) begin
			tail_lo_q <= sum_rdata[7:0];
		end
		if (state_q == crcts_pkg::ST_CRC_LOAD && wp_q == crcts_pkg::TAIL_HI_WORD) begin
			res_match_q <= hit;
			res_val_q   <= sum_rdata;
		end
		// Report the fresh word 14 as it is written back
		if (state_q == crcts_pkg::ST_ADD && rd_vld_s1 && addr_s1 == crcts_pkg::TAIL_HI_WORD) begin
			res_val_q <= add_sum;
		end
		if (state_q == crcts_pkg::ST_PUSH && push_ok) begin
			out_match_q <= res_match_q;
			out_val_q   <= res_val_q;
			out_total_q <= cnt_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_total_q, out_val_q};
	assign m_tuser  = out_match_q;

	// --------------------------------------------------------------------
	// Assertions
	// --------------------------------------------------------------------
	a_no_write_in_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == crcts_pkg::ST_CRC_RUN || state_q == crcts_pkg::ST_CRC_LOAD) |-> !sum_we)
		else $error("sum RAM written during CRC pass");

	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		sum_we |-> (sum_waddr < addr_t'(crcts_pkg::WORD_COUNT)))
		else $error("sum RAM write beyond word count");

	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (cnt_q >= $past(cnt_q)))
		else $error("test counter went backwards");

	a_test_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && mode == crcts_pkg::MODE_TEST) |=> (cnt_q != '0))
		else $error("test accepted without counting");

endmodule

// File: verif/crcts_checker.sv
`timescale 1ns / 100ps

module crcts_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [39:0]  s_tdata,  // [4:0] word_index, [36:5] word_value, [39:37] zero
	input  logic [1:0]   s_tuser,  // [1:0] mode
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [79:0]  m_tdata,  // [31:0] read_value, [79:32] tested_total
	input  logic [0:0]   m_tuser,  // [0] matched
	output int           errors,
	output int           pending
);

	localparam logic [31:0] REFLECT_POLY   = 32'hedb88320;
	localparam logic [31:0] TAIL_KEEP      = 32'hfffffffc;
	localparam int          TOP_WORD       = 22;
	localparam int          SHOWN_WORD     = 14;
	localparam int          FIRST_CAND     = 'h24;
	localparam int          FIRST_CRC_BYTE = 'h26;
	localparam int          LAST_CRC_BYTE  = 'h3f;
	localparam int          TAIL_BYTE      = 'h43;

	typedef struct {
		logic                          hit;
		logic [31:0]                   word;
		logic [crcts_pkg::COUNT_W-1:0] total;
	} outcome_t;

	logic [31:0]                   sum_mem  [crcts_pkg::WORD_COUNT];
	logic [31:0]                   step_mem [crcts_pkg::WORD_COUNT];
	logic [31:0]                   prefix;
	logic [crcts_pkg::COUNT_W-1:0] tests_run;
	outcome_t                      outcomes_due [$];

	initial begin
		errors  = 0;
		pending = 0;
		for (int i = 0; i < crcts_pkg::WORD_COUNT; i++) begin
			sum_mem[i]  = '0;
			step_mem[i] = '0;
		end
	end

	task automatic report(input string field, input logic [crcts_pkg::COUNT_W-1:0] got,
			input logic [crcts_pkg::COUNT_W-1:0] want);
		$display("%0t crcts_checker: %s got %0h want %0h", $time, field, got, want);
		errors++;
	endtask

	// candidate bytes 0x24.. come from sum words 22 downwards, big-endian
	function automatic logic [7:0] cand_byte(input int off);
		logic [31:0] w;
		int          rel;
		rel = off - FIRST_CAND;
		w   = sum_mem[TOP_WORD - rel / 4] >> (24 - 8 * (rel % 4));
		return w[7:0];
	endfunction

	function automatic logic tail_hit();
		logic [31:0] crc;
		logic [31:0] tail;
		crc = prefix;
		for (int off = FIRST_CRC_BYTE; off <= LAST_CRC_BYTE; off++) begin
			crc = crc ^ {24'd0, cand_byte(off)};
			for (int b = 0; b < 8; b++)
				crc = crc[0] ? ((crc >> 1) ^ REFLECT_POLY) : (crc >> 1);
		end
		tail = {cand_byte(TAIL_BYTE + 3), cand_byte(TAIL_BYTE + 2),
			cand_byte(TAIL_BYTE + 1), cand_byte(TAIL_BYTE)};
		return ((tail ^ ~crc) & TAIL_KEEP) == 32'd0;
	endfunction

	// carry out of the top word is dropped
	task automatic add_step();
		logic [32:0] acc;
		acc = '0;
		for (int i = 0; i < crcts_pkg::WORD_COUNT; i++) begin
			acc = {1'b0, sum_mem[i]} + {1'b0, step_mem[i]} + {32'd0, acc[32]};
			sum_mem[i] = acc[31:0];
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t         seen;
		outcome_t         due;
		outcome_t         fresh;
		logic [4:0]       idx;
		logic [31:0]      val;
		crcts_pkg::mode_t mode;
		if (!arst_n) begin
			prefix    = 32'hffffffff;
			tests_run = '0;
			outcomes_due.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				prefix = cfg_wdata;
			if (m_tvalid && m_tready) begin
				seen.hit   = m_tuser[0];
				seen.word  = m_tdata[31:0];
				seen.total = m_tdata[79:32];
				if (outcomes_due.size() == 0) begin
					report("result word with none due, read_value", seen.word, '0);
				end else begin
					due = outcomes_due.pop_front();
					if (seen.hit !== due.hit)
						report("matched", seen.hit, due.hit);
					if (seen.word !== due.word)
						report("read_value", seen.word, due.word);
					if (seen.total !== due.total)
						report("tested_total", seen.total, due.total);
				end
			end
			if (s_tvalid && s_tready) begin
				idx  = s_tdata[4:0];
				val  = s_tdata[36:5];
				mode = crcts_pkg::mode_t'(s_tuser);
				case (mode)
					crcts_pkg::MODE_LOAD_SUM: begin
						if (idx < crcts_pkg::WORD_COUNT)
							sum_mem[idx] = val;
					end
					crcts_pkg::MODE_LOAD_STEP: begin
						if (idx < crcts_pkg::WORD_COUNT)
							step_mem[idx] = val;
					end
					crcts_pkg::MODE_READ: begin
						fresh.hit   = 1'b0;
						fresh.word  = (idx < crcts_pkg::WORD_COUNT) ? sum_mem[idx] : 32'd0;
						fresh.total = tests_run;
						outcomes_due.push_back(fresh);
					end
					default: begin
						fresh.hit = tail_hit();
						if (tests_run != crcts_pkg::COUNT_MAX)
							tests_run = tests_run + 1'b1;
						if (!fresh.hit)
							add_step();
						fresh.word  = sum_mem[SHOWN_WORD];
						fresh.total = tests_run;
						outcomes_due.push_back(fresh);
					end
				endcase
			end
			pending <= outcomes_due.size();
		end
	end

endmodule

// File: verif/tb_crc_tail_signature_search.sv
`timescale 1ns / 100ps

module tb_crc_tail_signature_search;

	// whole running sum or step as one wide number, word 0 in the low bits
	localparam int SUM_BITS      = 32 * crcts_pkg::WORD_COUNT;
	// a load word answers nothing; give it room before a config write
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 100;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_WORDS   = 180;

	typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZERO, FILL_ONE, FILL_SPARSE} fill_t;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         cfg_we    = 1'b0;
	logic [31:0]  cfg_wdata = '0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [39:0]  s_tdata   = '0;  // [4:0] word_index, [36:5] word_value, [39:37] zero
	logic [1:0]   s_tuser   = '0;  // [1:0] mode
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [79:0]  m_tdata;         // [31:0] read_value, [79:32] tested_total
	logic [0:0]   m_tuser;         // [0] matched

	int           errors;
	int           pending;
	int           send_idle_pct  = 0;
	int           recv_stall_pct = 0;
	int           hold_asked     = 0;
	int           words_sent     = 0;
	logic [31:0]  prefix_now     = 32'hffffffff;

	always #2 clk = ~clk;

	crc_tail_signature_search u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	crcts_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.errors    (errors),
		.pending   (pending)
	);

	// Build a sum or step value of a given shape.
	function automatic logic [SUM_BITS-1:0] make_wide(input fill_t kind);
		logic [SUM_BITS-1:0] v;
		int                  w;
		v = '0;
		w = $urandom_range(crcts_pkg::WORD_COUNT - 1);
		case (kind)
			FILL_ONES:   v = '1;
			FILL_ZERO:   v = '0;
			FILL_ONE:    v[0] = 1'b1;
			FILL_SPARSE: v[32 * w +: 32] = $urandom;
			default: begin
				for (int i = 0; i < crcts_pkg::WORD_COUNT; i++)
					v[32 * i +: 32] = $urandom;
			end
		endcase
		return v;
	endfunction

	// Rewrite the tail bytes so that the candidate passes under the given prefix.
	// The CRC covers words 22 (low half) down to 16, so words 15 and 14 are free:
	// byte 0x43 is the low byte of word 15, bytes 0x44..0x46 the top three of word 14.
	// The two low tail bits are masked by the block; leave them as they are.
	function automatic logic [SUM_BITS-1:0] plant_match(input logic [SUM_BITS-1:0] s,
			input logic [31:0] pfx);
		logic [31:0] crc;
		logic [7:0]  b;
		int          rel;
		crc = pfx;
		for (int off = 'h26; off <= 'h3f; off++) begin
			rel = off - 'h24;
			b   = s[32 * (22 - rel / 4) + 24 - 8 * (rel % 4) +: 8];
			crc = crc ^ {24'd0, b};
			for (int k = 0; k < 8; k++)
				crc = crc[0] ? ((crc >> 1) ^ 32'hedb88320) : (crc >> 1);
		end
		crc = ~crc;
		s[32 * 15 + 2 +: 6]  = crc[7:2];
		s[32 * 14 + 8 +: 24] = {crc[15:8], crc[23:16], crc[31:24]};
		return s;
	endfunction

	// Offer one word, idling at random beforehand, and hold it until it is taken.
	// tvalid is only lowered when a gap is chosen, so back-to-back words stay high.
	task automatic put_word(input crcts_pkg::mode_t mode, input logic [4:0] idx,
			input logic [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {3'b000, val, idx};
		do
			@(posedge clk);
		while (!s_tready);
		// out-of-range loads are dropped by the block; do not count them
		if (mode == crcts_pkg::MODE_TEST || mode == crcts_pkg::MODE_READ ||
				idx < crcts_pkg::WORD_COUNT)
			words_sent++;
	endtask

	// Stop offering, wait for every due result, then give the block time to settle.
	task automatic drain_results(input int settle);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Only call with the block drained and settled.
	task automatic write_prefix(input logic [31:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		prefix_now  = v;
	endtask

	// Load every sum and step word, starting at a random word and walking either way.
	// With lead >= 0 the sum is set so that the tail check passes after lead steps.
	task automatic load_operands(input fill_t sum_kind, input fill_t step_kind, input int lead);
		logic [SUM_BITS-1:0] sum_v;
		logic [SUM_BITS-1:0] step_v;
		int                  at;
		int                  dir;
		sum_v  = make_wide(sum_kind);
		step_v = make_wide(step_kind);
		if (lead >= 0) begin
			sum_v = plant_match(sum_v, prefix_now);
			repeat (lead) sum_v = sum_v - step_v;
		end
		dir = $urandom_range(1) ? 1 : crcts_pkg::WORD_COUNT - 1;
		at  = $urandom_range(crcts_pkg::WORD_COUNT - 1);
		repeat (crcts_pkg::WORD_COUNT) begin
			put_word(crcts_pkg::MODE_LOAD_SUM, 5'(at), sum_v[32 * at +: 32]);
			at = (at + dir) % crcts_pkg::WORD_COUNT;
		end
		at = $urandom_range(crcts_pkg::WORD_COUNT - 1);
		repeat (crcts_pkg::WORD_COUNT) begin
			put_word(crcts_pkg::MODE_LOAD_STEP, 5'(at), step_v[32 * at +: 32]);
			at = (at + dir) % crcts_pkg::WORD_COUNT;
		end
	endtask

	// Test words, each now and then followed by a read of any index, in range or not.
	// Index and value are ignored on a test; randomise them all the same.
	task automatic run_tests(input int n);
		repeat (n) begin
			put_word(crcts_pkg::MODE_TEST, 5'($urandom_range(31)), $urandom);
			if ($urandom_range(2) == 0)
				put_word(crcts_pkg::MODE_READ, 5'($urandom_range(31)), $urandom);
		end
	endtask

	// Any mode, any index: only safe once every word has been loaded.
	task automatic run_noise(input int n);
		repeat (n)
			put_word(crcts_pkg::mode_t'($urandom_range(3)), 5'($urandom_range(31)), $urandom);
	endtask

	// Receiver: stall at random, or hold off for a long stretch when asked.
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Stimulus
	initial begin
		int quota;
		int pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reads past the last word answer zero, loads past it are dropped.
		put_word(crcts_pkg::MODE_READ, 5'd31, '1);
		put_word(crcts_pkg::MODE_READ, 5'd23, '0);
		put_word(crcts_pkg::MODE_LOAD_SUM, 5'd23, '1);
		put_word(crcts_pkg::MODE_LOAD_STEP, 5'd31, '1);
		// all-ones sum plus one wraps to zero, carry out of the top word lost
		load_operands(FILL_ONES, FILL_ONE, -1);
		run_tests(2);
		put_word(crcts_pkg::MODE_READ, 5'd0, '0);
		put_word(crcts_pkg::MODE_READ, 5'd22, '1);
		// zero sum plus all-ones step counts downwards
		load_operands(FILL_ZERO, FILL_ONES, -1);
		run_tests(2);
		// match on the first test, then the sum is held
		load_operands(FILL_RANDOM, FILL_ZERO, 0);
		run_tests(3);
		// match reached only after a few steps
		load_operands(FILL_SPARSE, FILL_RANDOM, 2);
		run_tests(4);

		// Random phases: idle and stall pressure per phase, new prefix between them.
		for (int p = 0; p < 4; p++) begin
			drain_results(SETTLE_CYCLES);
			case (p)
				0: write_prefix(32'h00000000);
				1: write_prefix(32'hffffffff);
				default: write_prefix($urandom);
			endcase
			send_idle_pct   = (p == 1) ? 49 : (p == 3) ? 35 : 0;
			recv_stall_pct <= (p == 2) ? 49 : (p == 3) ? 35 : 0;
			// long receiver hold-off while tests keep coming: the input must back up
			if (p == 0 || p == 3) begin
				hold_asked <= hold_asked + 1;
				run_tests(10);
			end
			quota = words_sent + PHASE_WORDS;
			while (words_sent < quota) begin
				pick = $urandom_range(9);
				if (pick < 3) begin
					load_operands(fill_t'($urandom_range(4)), fill_t'($urandom_range(4)),
						($urandom_range(2) == 0) ? $urandom_range(4) : -1);
					run_tests($urandom_range(1, 8));
				end else if (pick < 8) begin
					run_tests($urandom_range(1, 6));
				end else if (pick == 8) begin
					run_noise($urandom_range(1, 8));
				end else begin
					// pause the sender until everything due has come back
					drain_results(0);
					run_tests($urandom_range(1, 4));
				end
			end
		end

		drain_results(TAIL_CYCLES);
		if (errors == 0)
			$display("tb_crc_tail_signature_search: clean");
		else
			$display("tb_crc_tail_signature_search: errors");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#8_000_000;
		$display("tb_crc_tail_signature_search: errors");
		$finish;
	end

endmodule
